[hw/rtl/lmbph_pkg.sv]
// ----------------------------------------------------------------------------
// lmbph_pkg
// Shared widths, register map, reset values and the fixed-point scaling
// helper for the level meter ballistics and peak hold block.
// ----------------------------------------------------------------------------
package lmbph_pkg;

    // field widths
    localparam int LEVEL_BITS = 16;
    localparam int COEF_BITS  = 16;
    localparam int HOLD_BITS  = 8;
    localparam int PROD_BITS  = LEVEL_BITS + COEF_BITS;

    // apb register map
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = 2;
    localparam int PADDR_BITS   = REG_IDX_BITS + 2;

    localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_COEF     = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_COEF    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_PEAK_DECAY_COEF = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_HOLD_TICKS      = 2'd3;

    // register reset values
    localparam logic [COEF_BITS-1:0] ATTACK_COEF_RST     = 16'd26214;
    localparam logic [COEF_BITS-1:0] RELEASE_COEF_RST    = 16'd63570;
    localparam logic [COEF_BITS-1:0] PEAK_DECAY_COEF_RST = 16'd62915;
    localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RST      = 8'd60;

    // configuration seen by the datapath
    typedef struct packed {
        logic [COEF_BITS-1:0] attack_coef;
        logic [COEF_BITS-1:0] release_coef;
        logic [COEF_BITS-1:0] peak_decay_coef;
        logic [HOLD_BITS-1:0] hold_ticks;
    } cfg_t;

    // level times q0.16 coefficient, truncated back to level width
    function automatic logic [LEVEL_BITS-1:0] scale_q016(
        input logic [LEVEL_BITS-1:0] value,
        input logic [COEF_BITS-1:0]  coef
    );
        logic [PROD_BITS-1:0] prod;
        begin
            prod = PROD_BITS'(value) * PROD_BITS'(coef);
            return prod[PROD_BITS-1:COEF_BITS];
        end
    endfunction

endpackage

[hw/rtl/lmbph_tick_if.sv]
// ----------------------------------------------------------------------------
// lmbph_tick_if
// Valid/ready channel carrying one meter tick with the current level.
// ----------------------------------------------------------------------------
interface lmbph_tick_if
    import lmbph_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] current_level;

    modport source (output valid, output current_level, input ready);
    modport sink   (input valid, input current_level, output ready);
endinterface

[hw/rtl/lmbph_result_if.sv]
// ----------------------------------------------------------------------------
// lmbph_result_if
// Valid/ready channel carrying the smoothed level, peak and hold flag.
// ----------------------------------------------------------------------------
interface lmbph_result_if
    import lmbph_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] smoothed_level;
    logic [LEVEL_BITS-1:0] peak_level;
    logic                  peak_holding;

    modport source (output valid, output smoothed_level, output peak_level,
                    output peak_holding, input ready);
    modport sink   (input valid, input smoothed_level, input peak_level,
                    input peak_holding, output ready);
endinterface

[hw/rtl/lmbph_apb_regs.sv]
// ----------------------------------------------------------------------------
// lmbph_apb_regs
// APB register file holding the ballistics coefficients and hold time.
// ----------------------------------------------------------------------------
module lmbph_apb_regs
    import lmbph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[PADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ATTACK_COEF:     cfg_next.attack_coef     = pwdata[COEF_BITS-1:0];
                REG_RELEASE_COEF:    cfg_next.release_coef    = pwdata[COEF_BITS-1:0];
                REG_PEAK_DECAY_COEF: cfg_next.peak_decay_coef = pwdata[COEF_BITS-1:0];
                REG_HOLD_TICKS:      cfg_next.hold_ticks      = pwdata[HOLD_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coef     <= ATTACK_COEF_RST;
            cfg_reg.release_coef    <= RELEASE_COEF_RST;
            cfg_reg.peak_decay_coef <= PEAK_DECAY_COEF_RST;
            cfg_reg.hold_ticks      <= HOLD_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_ATTACK_COEF:     prdata = PDATA_BITS'(cfg_reg.attack_coef);
            REG_RELEASE_COEF:    prdata = PDATA_BITS'(cfg_reg.release_coef);
            REG_PEAK_DECAY_COEF: prdata = PDATA_BITS'(cfg_reg.peak_decay_coef);
            REG_HOLD_TICKS:      prdata = PDATA_BITS'(cfg_reg.hold_ticks);
            default:             prdata = '0;
        endcase
    end

endmodule

[hw/rtl/lmbph_core.sv]
// ----------------------------------------------------------------------------
// lmbph_core
// Input register, attack/release smoothing and peak hold update, and the
// result register, with one tick entering per cycle while results are taken.
// ----------------------------------------------------------------------------
module lmbph_core
    import lmbph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    lmbph_tick_if.sink            tick,
    lmbph_result_if.source        result
);

    // input stage
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [LEVEL_BITS-1:0] lvl_reg;

    // running state
    logic [LEVEL_BITS-1:0] smooth_reg;
    logic [LEVEL_BITS-1:0] smooth_next;
    logic [LEVEL_BITS-1:0] peak_reg;
    logic [LEVEL_BITS-1:0] peak_next;
    logic [HOLD_BITS-1:0]  hold_count_reg;
    logic [HOLD_BITS-1:0]  hold_count_next;

    // result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [LEVEL_BITS-1:0] out_smooth_reg;
    logic [LEVEL_BITS-1:0] out_peak_reg;
    logic                  out_holding_reg;

    logic                  tick_beat;
    logic                  advance;
    logic                  rising;
    logic [LEVEL_BITS-1:0] smooth_opnd;
    logic [COEF_BITS-1:0]  smooth_coef;
    logic [LEVEL_BITS-1:0] smooth_scaled;
    logic [LEVEL_BITS-1:0] peak_scaled;

    // handshake: the input stage moves on when the result register frees up
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready   = !in_valid_reg || advance;
    assign tick_beat    = tick.valid && tick.ready;

    assign in_valid_next  = tick_beat ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // smoothing: one shared multiplier for attack and release
    assign rising        = lvl_reg > smooth_reg;
    assign smooth_opnd   = rising ? (lvl_reg - smooth_reg) : smooth_reg;
    assign smooth_coef   = rising ? cfg.attack_coef : cfg.release_coef;
    assign smooth_scaled = scale_q016(smooth_opnd, smooth_coef);
    assign smooth_next   = rising ? (smooth_reg + smooth_scaled) : smooth_scaled;

    // peak hold and decay
    assign peak_scaled = scale_q016(peak_reg, cfg.peak_decay_coef);

    always_comb
    begin
        peak_next       = peak_reg;
        hold_count_next = hold_count_reg;
        if (lvl_reg > peak_reg)
        begin
            peak_next       = lvl_reg;
            hold_count_next = cfg.hold_ticks;
        end
        else if (hold_count_reg != '0)
        begin
            hold_count_next = hold_count_reg - HOLD_BITS'(1);
        end
        else
        begin
            peak_next = peak_scaled;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            smooth_reg     <= '0;
            peak_reg       <= '0;
            hold_count_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                smooth_reg     <= smooth_next;
                peak_reg       <= peak_next;
                hold_count_reg <= hold_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_beat)
        begin
            lvl_reg <= tick.current_level;
        end
        if (advance)
        begin
            out_smooth_reg  <= smooth_next;
            out_peak_reg    <= peak_next;
            out_holding_reg <= (hold_count_next != '0);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.smoothed_level = out_smooth_reg;
    assign result.peak_level     = out_peak_reg;
    assign result.peak_holding   = out_holding_reg;

endmodule

[hw/rtl/level_meter_ballistics_peak_hold.sv]
// ----------------------------------------------------------------------------
// level_meter_ballistics_peak_hold
// Level meter with attack/release smoothing and a held, decaying peak.
// ----------------------------------------------------------------------------
// A tick beat is captured in the input register, then in the result register,
// where its result beat is valid; a result not taken stalls both stages.
// Throughput: one tick per cycle while result.ready is high; the smoothing and
// peak update are 16x16 multiplies plus an add, fed by the state registers.
// Reset: rst_n clears smoothed level, peak and hold count to zero and loads
// the coefficient registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module level_meter_ballistics_peak_hold
    import lmbph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    lmbph_tick_if.sink            tick,
    lmbph_result_if.source        result
);

    cfg_t cfg;

    // configuration registers
    lmbph_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ballistics datapath
    lmbph_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .result (result)
    );

endmodule
